>>> rtl/core/cpet_pkg.sv
// Shared types for the collider pair event tracker.
// Event codes and the command and status groups between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpet_pkg;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } event_e;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/cpet_ctrl.sv
// Controller for the collider pair event tracker: clearing pass, accept, evaluate.
// Drives cpet_pkg::cmd_t to the datapath and reads cpet_pkg::status_t back.
// Depends on cpet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpet_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  input  cpet_pkg::status_t  status_i,
  output cpet_pkg::cmd_t     cmd_o
);
  import cpet_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.clr_en = (state_q == ST_CLEAR);
    cmd_o.load   = in_valid_i && (state_q == ST_IDLE);
    cmd_o.commit = (state_q == ST_EVAL) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!out_valid_q || out_ready_i) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_EVAL))
    else $error("accepted transaction did not enter evaluation");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.commit))
    else $error("result raised without a commit");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_i.clr_last && (state_q == ST_CLEAR)) |=> (state_q == ST_IDLE))
    else $error("clearing pass did not end at the last entry");

  a_no_commit_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_en |-> !cmd_o.commit && !cmd_o.load)
    else $error("table access during clearing pass");

endmodule

`default_nettype wire

>>> rtl/core/cpet_datapath.sv
// Datapath for the collider pair event tracker: overlap test, pair table, result register.
// Acts on cpet_pkg::cmd_t from cpet_ctrl and reports cpet_pkg::status_t.
// Depends on cpet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpet_datapath #(
  parameter int ID_BITS = 6
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  cpet_pkg::cmd_t            cmd_i,
  output cpet_pkg::status_t         status_o,
  input  wire        [ID_BITS-1:0]  first_id_i,
  input  wire        [ID_BITS-1:0]  second_id_i,
  input  wire signed [15:0]         first_x_i,
  input  wire signed [15:0]         first_y_i,
  input  wire        [15:0]         first_w_i,
  input  wire        [15:0]         first_h_i,
  input  wire signed [15:0]         second_x_i,
  input  wire signed [15:0]         second_y_i,
  input  wire        [15:0]         second_w_i,
  input  wire        [15:0]         second_h_i,
  input  wire                       first_dead_i,
  input  wire                       second_dead_i,
  output logic       [1:0]          event_res_o
);
  import cpet_pkg::*;

  localparam int PairBits = 2 * ID_BITS;
  localparam int Depth    = 1 << PairBits;

  function automatic logic axis_hit(logic signed [15:0] ac, logic [15:0] as,
                                    logic signed [15:0] bc, logic [15:0] bs);
    logic signed [16:0] diff;
    logic        [16:0] mag;
    logic        [17:0] twice;
    logic        [16:0] sum;
    diff  = {bc[15], bc} - {ac[15], ac};
    mag   = diff[16] ? 17'(-diff) : 17'(diff);
    twice = {mag, 1'b0};
    sum   = {1'b0, as} + {1'b0, bs};
    return twice < {1'b0, sum};
  endfunction

  logic                 table_q [Depth];
  logic                 was_q;
  logic [PairBits-1:0]  idx_q;
  logic                 same_q;
  logic                 hit_q;
  logic                 dead_q;
  event_e               event_q;
  logic [PairBits-1:0]  clr_cnt_q;

  logic [PairBits-1:0]  idx_in;
  event_e               ev;
  logic                 wr_en;

  assign idx_in            = {first_id_i, second_id_i};
  assign status_o.clr_last = &clr_cnt_q;
  assign event_res_o       = event_q;

  always_comb begin
    ev    = EV_NONE;
    wr_en = 1'b0;
    if (same_q) begin
      ev = EV_NONE;
    end else if (hit_q) begin
      if (was_q) begin
        if (dead_q) begin
          ev    = EV_EXIT;
          wr_en = 1'b1;
        end else begin
          ev = EV_STAY;
        end
      end else if (!dead_q) begin
        ev    = EV_ENTER;
        wr_en = 1'b1;
      end
    end else if (was_q) begin
      ev    = EV_EXIT;
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      table_q[clr_cnt_q] <= 1'b0;
    end else if (cmd_i.commit && wr_en) begin
      table_q[idx_q] <= (ev == EV_ENTER);
    end
    if (cmd_i.load) begin
      was_q <= table_q[idx_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q  <= idx_in;
      same_q <= (first_id_i == second_id_i);
      dead_q <= first_dead_i | second_dead_i;
      hit_q  <= axis_hit(first_x_i, first_w_i, second_x_i, second_w_i) &&
                axis_hit(first_y_i, first_h_i, second_y_i, second_h_i);
    end
    if (cmd_i.commit) begin
      event_q <= ev;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/collision_pair_event_tracker.sv
// Collider pair event tracker: AABB overlap test with enter, stay and exit tracking.
// Joins cpet_ctrl and cpet_datapath.
// Depends on cpet_pkg, cpet_ctrl, cpet_datapath.
//
// Each input transaction carries one ordered collider pair and yields exactly one
// event_res (0 none, 1 enter, 2 stay, 3 exit). The accept edge reads the pair's
// touching bit from the single-port table and registers the overlap test; in the
// evaluation state the commit writes the bit back and loads the result register.
// The result register lets the next transaction be accepted while a result waits;
// the evaluation cycle holds only while that register is still full. After reset
// the table is cleared one entry per cycle, all 2^(2*ID_BITS) entries (4096 at the
// default), and in_ready_o stays low until that pass is done.
`timescale 1ns / 1ps
`default_nettype none

module collision_pair_event_tracker #(
  parameter int ID_BITS = 6
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire        [ID_BITS-1:0]  first_id_i,
  input  wire        [ID_BITS-1:0]  second_id_i,
  input  wire signed [15:0]         first_x_i,
  input  wire signed [15:0]         first_y_i,
  input  wire        [15:0]         first_w_i,
  input  wire        [15:0]         first_h_i,
  input  wire signed [15:0]         second_x_i,
  input  wire signed [15:0]         second_y_i,
  input  wire        [15:0]         second_w_i,
  input  wire        [15:0]         second_h_i,
  input  wire                       first_dead_i,
  input  wire                       second_dead_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic       [1:0]          event_res_o
);
  import cpet_pkg::*;

  cmd_t    cmd;
  status_t status;

  cpet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cpet_datapath #(
    .ID_BITS (ID_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .first_id_i    (first_id_i),
    .second_id_i   (second_id_i),
    .first_x_i     (first_x_i),
    .first_y_i     (first_y_i),
    .first_w_i     (first_w_i),
    .first_h_i     (first_h_i),
    .second_x_i    (second_x_i),
    .second_y_i    (second_y_i),
    .second_w_i    (second_w_i),
    .second_h_i    (second_h_i),
    .first_dead_i  (first_dead_i),
    .second_dead_i (second_dead_i),
    .event_res_o   (event_res_o)
  );

endmodule

`default_nettype wire

>>> dv/collision_pair_event_tracker_test.sv
// Self-checking testbench for collision_pair_event_tracker: directed and random collider pairs.
// Predicts every event in a scoreboard class with its own touching map; both sides idle at random.
// Depends on cpet_pkg and collision_pair_event_tracker.
`timescale 1ns / 1ps

module collision_pair_event_tracker_test;
  import cpet_pkg::*;

  localparam int ID_W           = 6;
  localparam int PAIRS          = 1 << (2 * ID_W);
  localparam int RANDOM_ITEMS   = 1650;
  localparam int HOLD_AT        = 500;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 10;

  typedef enum int {
    GEO_NEAR,
    GEO_WILD,
    GEO_EDGE,
    GEO_CORNER
  } geo_e;

  typedef struct packed {
    logic [ID_W-1:0] a_id;
    logic [ID_W-1:0] b_id;
    logic [15:0]     ax;
    logic [15:0]     ay;
    logic [15:0]     aw;
    logic [15:0]     ah;
    logic [15:0]     bx;
    logic [15:0]     by;
    logic [15:0]     bw;
    logic [15:0]     bh;
    logic            a_dead;
    logic            b_dead;
  } pair_t;

  class event_scoreboard;
    bit     touch_map [PAIRS];
    event_e pending_q [$];
    int     errors;
    int     seen [4];

    function new();
      errors = 0;
      foreach (touch_map[i]) touch_map[i] = 1'b0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    function bit axis_hit(logic [15:0] ac, logic [15:0] as, logic [15:0] bc, logic [15:0] bs);
      longint d;
      longint sum;
      d   = longint'($signed(bc)) - longint'($signed(ac));
      sum = longint'(as) + longint'(bs);
      if (d < 0) d = -d;
      return (2 * d) < sum;
    endfunction

    function void note(pair_t p);
      logic [2*ID_W-1:0] idx;
      bit                hit;
      bit                was;
      bit                dead;
      event_e            ev;
      ev = EV_NONE;
      if (p.a_id != p.b_id) begin
        idx  = {p.a_id, p.b_id};
        dead = p.a_dead | p.b_dead;
        hit  = axis_hit(p.ax, p.aw, p.bx, p.bw) && axis_hit(p.ay, p.ah, p.by, p.bh);
        was  = touch_map[idx];
        if (hit) begin
          if (was) begin
            if (dead) begin
              ev = EV_EXIT;
              touch_map[idx] = 1'b0;
            end else begin
              ev = EV_STAY;
            end
          end else if (!dead) begin
            ev = EV_ENTER;
            touch_map[idx] = 1'b1;
          end
        end else if (was) begin
          ev = EV_EXIT;
          touch_map[idx] = 1'b0;
        end
      end
      pending_q.push_back(ev);
    endfunction

    task check(logic [1:0] got);
      event_e want;
      if (pending_q.size() == 0) begin
        report($sformatf("event_res %0d with no transaction pending", got));
      end else begin
        want = pending_q.pop_front();
        seen[want]++;
        if (got !== want)
          report($sformatf("event_res got %0d, want %0d (%s)", got, want, want.name()));
      end
    endtask

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ID_W-1:0]   first_id_i = '0;
  logic [ID_W-1:0]   second_id_i = '0;
  logic signed [15:0] first_x_i = '0;
  logic signed [15:0] first_y_i = '0;
  logic [15:0]       first_w_i = '0;
  logic [15:0]       first_h_i = '0;
  logic signed [15:0] second_x_i = '0;
  logic signed [15:0] second_y_i = '0;
  logic [15:0]       second_w_i = '0;
  logic [15:0]       second_h_i = '0;
  logic              first_dead_i = 1'b0;
  logic              second_dead_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        event_res_o;

  event_scoreboard sb = new();
  int items_sent   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;

  collision_pair_event_tracker #(.ID_BITS(ID_W)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .first_id_i    (first_id_i),
    .second_id_i   (second_id_i),
    .first_x_i     (first_x_i),
    .first_y_i     (first_y_i),
    .first_w_i     (first_w_i),
    .first_h_i     (first_h_i),
    .second_x_i    (second_x_i),
    .second_y_i    (second_y_i),
    .second_w_i    (second_w_i),
    .second_h_i    (second_h_i),
    .first_dead_i  (first_dead_i),
    .second_dead_i (second_dead_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("collision_pair_event_tracker: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pair_t build_pair(int a, int b, int ax, int ay, int aw, int ah,
                                       int bx, int by, int bw, int bh, bit ad, bit bd);
    pair_t p;
    p.a_id = ID_W'(a);  p.b_id = ID_W'(b);
    p.ax = 16'(ax);   p.ay = 16'(ay);   p.aw = 16'(aw);   p.ah = 16'(ah);
    p.bx = 16'(bx);   p.by = 16'(by);   p.bw = 16'(bw);   p.bh = 16'(bh);
    p.a_dead = ad;
    p.b_dead = bd;
    return p;
  endfunction

  function automatic void rand_axis(input geo_e mode, output logic [15:0] ac,
                                    output logic [15:0] as, output logic [15:0] bc,
                                    output logic [15:0] bs);
    logic [15:0] pos_corner [4];
    logic [15:0] size_corner [4];
    int dd;
    int sum;
    pos_corner  = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    size_corner = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
    case (mode)
      GEO_NEAR: begin
        ac = 16'($urandom);
        bc = ac + 16'($urandom_range(0, 400)) - 16'd200;
        as = 16'($urandom_range(0, 400));
        bs = 16'($urandom_range(0, 400));
      end
      GEO_WILD: begin
        ac = 16'($urandom);
        bc = 16'($urandom);
        as = 16'($urandom);
        bs = 16'($urandom);
      end
      GEO_EDGE: begin
        dd  = $urandom_range(0, 300);
        sum = 2 * dd + int'($urandom_range(0, 1));
        ac  = 16'($urandom);
        bc  = $urandom_range(0, 1) ? ac + 16'(dd) : ac - 16'(dd);
        as  = 16'($urandom_range(0, sum));
        bs  = 16'(sum - int'(as));
      end
      default: begin
        ac = pos_corner[2'($urandom_range(0, 3))];
        bc = pos_corner[2'($urandom_range(0, 3))];
        as = size_corner[2'($urandom_range(0, 3))];
        bs = size_corner[2'($urandom_range(0, 3))];
      end
    endcase
  endfunction

  function automatic pair_t rand_pair(int a, int b);
    pair_t p;
    int    r;
    geo_e  mode;
    r = $urandom_range(0, 99);
    mode = (r < 55) ? GEO_NEAR : (r < 75) ? GEO_WILD : (r < 88) ? GEO_EDGE : GEO_CORNER;
    p.a_id = ID_W'(a);
    p.b_id = ID_W'(b);
    rand_axis(mode, p.ax, p.aw, p.bx, p.bw);
    rand_axis(mode, p.ay, p.ah, p.by, p.bh);
    p.a_dead = ($urandom_range(0, 99) < 8);
    p.b_dead = ($urandom_range(0, 99) < 8);
    return p;
  endfunction

  task automatic push(input pair_t p, input int gap);
    in_valid_i    <= 1'b1;
    first_id_i    <= p.a_id;
    second_id_i   <= p.b_id;
    first_x_i     <= p.ax;
    first_y_i     <= p.ay;
    first_w_i     <= p.aw;
    first_h_i     <= p.ah;
    second_x_i    <= p.bx;
    second_y_i    <= p.by;
    second_w_i    <= p.bw;
    second_h_i    <= p.bh;
    first_dead_i  <= p.a_dead;
    second_dead_i <= p.b_dead;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(p);
    items_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    pair_t directed [$];
    int    a;
    int    b;
    int    run_left;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(build_pair(0, 0, 0, 0, 100, 100, 0, 0, 100, 100, 0, 0));
    directed.push_back(build_pair(1, 2, 0, 0, 100, 100, 10, 10, 100, 100, 0, 0));
    directed.push_back(build_pair(1, 2, 0, 0, 100, 100, 10, 10, 100, 100, 0, 0));
    directed.push_back(build_pair(2, 1, 0, 0, 100, 100, 10, 10, 100, 100, 0, 0));
    directed.push_back(build_pair(1, 2, 0, 0, 100, 100, 10, 10, 100, 100, 1, 0));
    directed.push_back(build_pair(1, 2, 0, 0, 100, 100, 10, 10, 100, 100, 0, 1));
    directed.push_back(build_pair(1, 2, 0, 0, 100, 100, 10, 10, 100, 100, 0, 0));
    directed.push_back(build_pair(1, 2, 0, 0, 10, 10, 500, 0, 10, 10, 0, 0));
    directed.push_back(build_pair(2, 1, 0, 0, 10, 10, 0, 500, 10, 10, 1, 1));
    directed.push_back(build_pair(63, 62, -32768, -32768, 65535, 65535,
                                  32767, 32767, 65535, 65535, 0, 0));
    directed.push_back(build_pair(63, 62, -32768, 32767, 65535, 65535,
                                  -32768, 32767, 65535, 65535, 0, 0));
    directed.push_back(build_pair(63, 62, -32768, 32767, 65535, 65535,
                                  -32768, 32767, 65535, 65535, 1, 1));
    directed.push_back(build_pair(0, 63, 5, 5, 0, 0, 5, 5, 0, 0, 0, 0));
    directed.push_back(build_pair(0, 63, 5, 5, 0, 1, 5, 5, 1, 0, 0, 0));
    directed.push_back(build_pair(0, 63, 5, 5, 0, 1, 5, 5, 1, 1, 0, 0));
    directed.push_back(build_pair(3, 4, 0, 0, 30, 40, 20, 20, 10, 0, 0, 0));
    directed.push_back(build_pair(3, 4, 0, 0, 30, 40, 20, 20, 11, 1, 0, 0));
    directed.push_back(build_pair(3, 4, 0, 0, 30, 40, -20, -20, 11, 1, 0, 0));
    directed.push_back(build_pair(3, 4, 0, 0, 30, 40, -20, -20, 10, 1, 0, 0));
    directed.push_back(build_pair(5, 6, 32767, 32767, 65535, 65535,
                                  32767, 32767, 0, 0, 1, 1));
    directed.push_back(build_pair(63, 63, -1, -1, 65535, 65535, -1, -1, 65535, 65535, 1, 1));
    foreach (directed[i]) push(directed[i], pick_gap(i < 8));

    run_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (run_left == 0) begin
        if ($urandom_range(0, 9) < 7) begin
          a = $urandom_range(0, 5);
          b = $urandom_range(0, 5);
        end else begin
          a = $urandom_range(0, 63);
          b = $urandom_range(0, 63);
        end
        run_left = $urandom_range(1, 6);
      end
      run_left--;
      push(rand_pair(a, b), (n == RANDOM_ITEMS - 1) ? 1 : pick_gap(((n / 64) % 4) == 3));
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d pairs (directed corners, ordered ids, dead flags, boundaries, random)",
             items_sent);
    $display("checked %0d events: none %0d, enter %0d, stay %0d, exit %0d; one long hold-off",
             results_seen, sb.seen[EV_NONE], sb.seen[EV_ENTER], sb.seen[EV_STAY],
             sb.seen[EV_EXIT]);
    if (sb.errors == 0) begin
      $display("collision_pair_event_tracker: match");
    end else begin
      $display("collision_pair_event_tracker: mismatch");
    end
    $finish;
  end

  initial begin
    int stall;
    bit held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen == HOLD_AT) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = pick_gap(((results_seen / 64) % 4) == 1);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check(event_res_o);
      results_seen++;
    end
  end

endmodule

>>> files.f
rtl/core/cpet_pkg.sv
rtl/core/cpet_ctrl.sv
rtl/core/cpet_datapath.sv
rtl/core/collision_pair_event_tracker.sv
dv/collision_pair_event_tracker_test.sv
